// ----- rtl/rfd_pkg.sv -----
// Shared types and codes for the request frame deframer.
package rfd_pkg;

  // Default field widths for body lengths and string counts
  localparam int DefaultLengthBits = 26;
  localparam int DefaultCountBits  = 18;

  // Fixed widths of the register and result fields
  localparam int MaxLenWidth = 26;
  localparam int MaxStrWidth = 18;
  localparam int IndexWidth  = 18;

  // Register reset values
  localparam logic [MaxLenWidth-1:0] MaxMsgLenReset  = MaxLenWidth'(32 << 20);
  localparam logic [MaxStrWidth-1:0] MaxStringsReset = MaxStrWidth'(200 * 1000);

  // Register indexes (paddr[2])
  localparam logic RegMaxMsgLen  = 1'b0;
  localparam logic RegMaxStrings = 1'b1;

  // Parser phases
  localparam logic [1:0] PhLen    = 2'd0;
  localparam logic [1:0] PhCount  = 2'd1;
  localparam logic [1:0] PhStrLen = 2'd2;
  localparam logic [1:0] PhData   = 2'd3;

  // Result kinds
  localparam logic [1:0] KindByte    = 2'd0;
  localparam logic [1:0] KindStrDone = 2'd1;
  localparam logic [1:0] KindReqDone = 2'd2;
  localparam logic [1:0] KindError   = 2'd3;

  // Error codes
  localparam logic [1:0] ErrNone    = 2'd0;
  localparam logic [1:0] ErrTooLong = 2'd1;
  localparam logic [1:0] ErrBadReq  = 2'd2;

  // One result item
  typedef struct packed {
    logic [1:0]            kind;
    logic [7:0]            payload;
    logic [IndexWidth-1:0] string_index;
    logic [1:0]            error_code;
    logic                  last;
  } result_t;

endpackage

// ----- rtl/rfd_step.sv -----
// Per-byte parser step: next state and up to three result items.
module rfd_step import rfd_pkg::*; #(
  parameter int LENGTH_BITS = DefaultLengthBits,
  parameter int COUNT_BITS  = DefaultCountBits
) (
  input  logic [7:0]             rx_byte_i,
  input  logic [MaxLenWidth-1:0] max_msg_len_i,
  input  logic [MaxStrWidth-1:0] max_strings_i,
  input  logic [1:0]             phase_i,
  input  logic [1:0]             fbc_i,
  input  logic [31:0]            fval_i,
  input  logic [LENGTH_BITS-1:0] body_left_i,
  input  logic [COUNT_BITS-1:0]  str_left_i,
  input  logic [LENGTH_BITS-1:0] sbytes_left_i,
  input  logic [COUNT_BITS-1:0]  cur_str_i,
  input  logic                   closed_i,
  output logic [1:0]             phase_o,
  output logic [1:0]             fbc_o,
  output logic [31:0]            fval_o,
  output logic [LENGTH_BITS-1:0] body_left_o,
  output logic [COUNT_BITS-1:0]  str_left_o,
  output logic [LENGTH_BITS-1:0] sbytes_left_o,
  output logic [COUNT_BITS-1:0]  cur_str_o,
  output logic                   closed_o,
  output result_t [2:0]          res_o,
  output logic [1:0]             res_cnt_o
);

  // Largest values the length and count fields can hold
  localparam logic [32:0] LenMax = (33'd1 << LENGTH_BITS) - 33'd1;
  localparam logic [32:0] CntMax = (33'd1 << COUNT_BITS) - 33'd1;

  logic [31:0] v;
  logic        do_sd;
  logic        do_fin;
  logic        do_need;
  logic [1:0]  need_phase;
  logic [1:0]  n;

  always_comb begin
    phase_o       = phase_i;
    fbc_o         = fbc_i;
    fval_o        = fval_i;
    body_left_o   = body_left_i;
    str_left_o    = str_left_i;
    sbytes_left_o = sbytes_left_i;
    cur_str_o     = cur_str_i;
    closed_o      = closed_i;
    res_o         = '0;
    n             = 2'd0;
    v             = '0;
    do_sd         = 1'b0;
    do_fin        = 1'b0;
    do_need       = 1'b0;
    need_phase    = PhStrLen;

    if (!closed_i) begin
      if (phase_i == PhData) begin
        // string byte
        res_o[n].kind         = KindByte;
        res_o[n].payload      = rx_byte_i;
        res_o[n].string_index = IndexWidth'(cur_str_i);
        n = n + 2'd1;
        if (body_left_o != '0) body_left_o = body_left_o - 1'b1;
        if (sbytes_left_o != '0) sbytes_left_o = sbytes_left_o - 1'b1;
        if (sbytes_left_o == '0) do_sd = 1'b1;
      end else begin
        // header field byte, little endian
        if (phase_i != PhLen && body_left_o != '0) body_left_o = body_left_o - 1'b1;
        fval_o = fval_i | (32'(rx_byte_i) << {fbc_i, 3'b000});
        if (fbc_i != 2'd3) begin
          fbc_o = fbc_i + 2'd1;
        end else begin
          v      = fval_o;
          fbc_o  = 2'd0;
          fval_o = '0;
          if (phase_i == PhCount) begin
            if ({1'b0, v} > 33'(max_strings_i) || {1'b0, v} > CntMax) begin
              res_o[n].kind       = KindError;
              res_o[n].error_code = ErrBadReq;
              n = n + 2'd1;
              closed_o = 1'b1;
            end else begin
              str_left_o = v[COUNT_BITS-1:0];
              cur_str_o  = '0;
              if (v == '0) do_fin = 1'b1;
              else begin
                do_need    = 1'b1;
                need_phase = PhStrLen;
              end
            end
          end else if (phase_i == PhStrLen) begin
            if ({1'b0, v} > 33'(body_left_o)) begin
              res_o[n].kind       = KindError;
              res_o[n].error_code = ErrBadReq;
              n = n + 2'd1;
              closed_o = 1'b1;
            end else begin
              sbytes_left_o = v[LENGTH_BITS-1:0];
              if (v == '0) do_sd = 1'b1;
              else phase_o = PhData;
            end
          end else begin
            if ({1'b0, v} > 33'(max_msg_len_i) || {1'b0, v} > LenMax) begin
              res_o[n].kind       = KindError;
              res_o[n].error_code = ErrTooLong;
              n = n + 2'd1;
              closed_o = 1'b1;
            end else begin
              body_left_o = v[LENGTH_BITS-1:0];
              do_need     = 1'b1;
              need_phase  = PhCount;
            end
          end
        end
      end

      // string done
      if (do_sd) begin
        res_o[n].kind         = KindStrDone;
        res_o[n].string_index = IndexWidth'(cur_str_i);
        n = n + 2'd1;
        str_left_o = str_left_o - 1'b1;
        cur_str_o  = cur_str_i + 1'b1;
        if (str_left_o == '0) do_fin = 1'b1;
        else begin
          do_need    = 1'b1;
          need_phase = PhStrLen;
        end
      end

      // next 4-byte field must fit in the body
      if (do_need) begin
        if (body_left_o < LENGTH_BITS'(4)) begin
          res_o[n].kind       = KindError;
          res_o[n].error_code = ErrBadReq;
          n = n + 2'd1;
          closed_o = 1'b1;
        end else begin
          phase_o = need_phase;
        end
      end

      // request end: no leftover body bytes allowed
      if (do_fin) begin
        if (body_left_o != '0) begin
          res_o[n].kind       = KindError;
          res_o[n].error_code = ErrBadReq;
          closed_o = 1'b1;
        end else begin
          res_o[n].kind = KindReqDone;
          phase_o       = PhLen;
        end
        n = n + 2'd1;
      end

      if (n != 2'd0) res_o[n - 2'd1].last = 1'b1;
    end
    res_cnt_o = n;
  end

endmodule

// ----- rtl/request_frame_deframer_unit.sv -----
// Top level of the request frame deframer: state, result buffer, APB registers.
//
// Input channel: one received byte per item (rx_byte_i), valid/stall handshake.
// Output channel: one result per item (kind, payload, string_index, error_code,
// last); last marks the final result caused by one input byte.
// Each byte is parsed in the cycle it is accepted and its 0 to 3 results are
// written into a three-entry result buffer; the first result is offered on
// the next cycle.
// Throughput: one byte per cycle while each byte yields at most one result
// and out_stall_i is low. A byte that yields more than one result holds the
// input off while the result buffer drains, one result per unstalled cycle.
// When out_stall_i is high the current result holds and no new byte is
// accepted until the last buffered result is being taken.
// Reset empties the buffer, returns the parser to waiting for a body length
// and loads the limit registers with their defaults.
// After any error the unit closes and drops every byte until reset.
// Registers (APB, byte address): 0x0 max_message_len, 0x4 max_strings.
module request_frame_deframer_unit import rfd_pkg::*; #(
  parameter int LENGTH_BITS = DefaultLengthBits,
  parameter int COUNT_BITS  = DefaultCountBits
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // byte input
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [7:0]            rx_byte_i,
  // result output
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [1:0]            kind_o,
  output logic [7:0]            payload_o,
  output logic [IndexWidth-1:0] string_index_o,
  output logic [1:0]            error_code_o,
  output logic                  last_o,
  // register port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic [MaxLenWidth-1:0] max_msg_len_q;
  logic [MaxStrWidth-1:0] max_strings_q;

  logic [1:0]             phase_q, phase_d;
  logic [1:0]             fbc_q, fbc_d;
  logic [31:0]            fval_q, fval_d;
  logic [LENGTH_BITS-1:0] body_left_q, body_left_d;
  logic [COUNT_BITS-1:0]  str_left_q, str_left_d;
  logic [LENGTH_BITS-1:0] sbytes_left_q, sbytes_left_d;
  logic [COUNT_BITS-1:0]  cur_str_q, cur_str_d;
  logic                   closed_q, closed_d;

  result_t [2:0] res_q, res_d;
  logic [1:0]    res_cnt_q, res_cnt_d;
  logic [1:0]    rd_ptr_q;
  result_t       res_out;

  logic take;
  logic drain_last;
  logic accept;

  // Register port
  assign pready = 1'b1;

  always_comb begin
    case (paddr[2])
      RegMaxMsgLen:  prdata = 32'(max_msg_len_q);
      RegMaxStrings: prdata = 32'(max_strings_q);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_msg_len_q <= MaxMsgLenReset;
      max_strings_q <= MaxStringsReset;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == RegMaxMsgLen) max_msg_len_q <= pwdata[MaxLenWidth-1:0];
      else                          max_strings_q <= pwdata[MaxStrWidth-1:0];
    end
  end

  // Handshake: take a byte once the buffer is empty or its last result leaves
  assign out_valid_o = (rd_ptr_q != res_cnt_q);
  assign take        = out_valid_o && !out_stall_i;
  assign drain_last  = take && ((rd_ptr_q + 2'd1) == res_cnt_q);
  assign in_stall_o  = out_valid_o && !drain_last;
  assign accept      = in_valid_i && !in_stall_o;

  // Parser step
  rfd_step #(
    .LENGTH_BITS (LENGTH_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_step (
    .rx_byte_i     (rx_byte_i),
    .max_msg_len_i (max_msg_len_q),
    .max_strings_i (max_strings_q),
    .phase_i       (phase_q),
    .fbc_i         (fbc_q),
    .fval_i        (fval_q),
    .body_left_i   (body_left_q),
    .str_left_i    (str_left_q),
    .sbytes_left_i (sbytes_left_q),
    .cur_str_i     (cur_str_q),
    .closed_i      (closed_q),
    .phase_o       (phase_d),
    .fbc_o         (fbc_d),
    .fval_o        (fval_d),
    .body_left_o   (body_left_d),
    .str_left_o    (str_left_d),
    .sbytes_left_o (sbytes_left_d),
    .cur_str_o     (cur_str_d),
    .closed_o      (closed_d),
    .res_o         (res_d),
    .res_cnt_o     (res_cnt_d)
  );

  // Parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PhLen;
      fbc_q         <= '0;
      fval_q        <= '0;
      body_left_q   <= '0;
      str_left_q    <= '0;
      sbytes_left_q <= '0;
      cur_str_q     <= '0;
      closed_q      <= 1'b0;
    end else if (accept) begin
      phase_q       <= phase_d;
      fbc_q         <= fbc_d;
      fval_q        <= fval_d;
      body_left_q   <= body_left_d;
      str_left_q    <= str_left_d;
      sbytes_left_q <= sbytes_left_d;
      cur_str_q     <= cur_str_d;
      closed_q      <= closed_d;
    end
  end

  // Result buffer control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_cnt_q <= '0;
      rd_ptr_q  <= '0;
    end else if (accept) begin
      res_cnt_q <= res_cnt_d;
      rd_ptr_q  <= '0;
    end else if (take) begin
      rd_ptr_q  <= rd_ptr_q + 2'd1;
    end
  end

  // Result buffer data
  always_ff @(posedge clk_i) begin
    if (accept) res_q <= res_d;
  end

  // Output select
  always_comb begin
    case (rd_ptr_q)
      2'd0:    res_out = res_q[0];
      2'd1:    res_out = res_q[1];
      2'd2:    res_out = res_q[2];
      default: res_out = res_q[0];
    endcase
  end

  assign kind_o         = res_out.kind;
  assign payload_o      = res_out.payload;
  assign string_index_o = res_out.string_index;
  assign error_code_o   = res_out.error_code;
  assign last_o         = res_out.last;

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the request frame deframer unit.
module tb_top import rfd_pkg::*; ();

  localparam int LenBits     = DefaultLengthBits;
  localparam int CntBits     = DefaultCountBits;
  localparam int LongHold    = 80;
  localparam int CycleLimit  = 300000;
  localparam int DrainCycles = 20;
  localparam int IdleGuard   = 6;

  // Two requests: strings "" and 8'hFF, then an empty request (count zero)
  localparam logic [7:0] DirBytes [25] = '{
    8'h0D, 8'h00, 8'h00, 8'h00,  8'h02, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00,  8'h01, 8'h00, 8'h00, 8'h00,
    8'hFF,
    8'h04, 8'h00, 8'h00, 8'h00,  8'h00, 8'h00, 8'h00, 8'h00
  };

  // n < 0: row is checked against the predictor
  typedef struct {
    logic [7:0] b;
    int         n;
    result_t    r [3];
  } stim_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [7:0]            rx_byte_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [1:0]            kind_o;
  logic [7:0]            payload_o;
  logic [IndexWidth-1:0] string_index_o;
  logic [1:0]            error_code_o;
  logic                  last_o;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [2:0]            paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  request_frame_deframer_unit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .payload_o      (payload_o),
    .string_index_o (string_index_o),
    .error_code_o   (error_code_o),
    .last_o         (last_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // Deframer state as seen by the predictor
  logic [1:0]            ph;
  logic [1:0]            fld_cnt;
  logic [31:0]           fld_val;
  logic [LenBits-1:0]    body_left;
  logic [CntBits-1:0]    strs_left;
  logic [LenBits-1:0]    str_left;
  logic [IndexWidth-1:0] str_idx;
  logic                  closed_flag;
  logic [MaxLenWidth-1:0] lim_msg_len;
  logic [MaxStrWidth-1:0] lim_strings;

  result_t byte_events[$];  // events caused by the byte just taken
  result_t events_due[$];   // events still to come out of the unit

  bit quiet;
  bit hold_go;
  int cycles;
  int bytes_in;
  int results_seen;
  int mismatches;
  int settings_used;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycles <= cycles + 1;

  // Watchdog
  initial begin : watchdog
    while (cycles < CycleLimit) @(posedge clk_i);
    $display("timeout after %0d cycles, %0d events outstanding", cycles, events_due.size());
    $display("Regression FAIL");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 40) $display("mismatch at cycle %0d: %s", cycles, msg);
  endtask

  // ---------------------------------------------------------------- predictor

  function automatic result_t make_event(logic [1:0] k, logic [7:0] pl,
                                         logic [IndexWidth-1:0] idx, logic [1:0] ec,
                                         logic lst);
    result_t r;
    r.kind         = k;
    r.payload      = pl;
    r.string_index = idx;
    r.error_code   = ec;
    r.last         = lst;
    return r;
  endfunction

  function automatic void note(logic [1:0] k, logic [7:0] pl, logic [IndexWidth-1:0] idx,
                               logic [1:0] ec);
    byte_events.insert(byte_events.size(), make_event(k, pl, idx, ec, 1'b0));
  endfunction

  // Any error closes the deframer for good
  function automatic void close_with(logic [1:0] ec);
    note(KindError, 8'h00, '0, ec);
    closed_flag = 1'b1;
  endfunction

  // The next 4-byte field has to fit in the body
  function automatic void need_word(logic [1:0] next_ph);
    if (body_left < 4) close_with(ErrBadReq);
    else ph = next_ph;
  endfunction

  function automatic void end_request();
    if (body_left != 0) begin
      close_with(ErrBadReq);
    end else begin
      note(KindReqDone, 8'h00, '0, ErrNone);
      ph = PhLen;
    end
  endfunction

  function automatic void end_string();
    note(KindStrDone, 8'h00, str_idx, ErrNone);
    strs_left = strs_left - 1'b1;
    str_idx   = str_idx + 1'b1;
    if (strs_left == 0) end_request();
    else need_word(PhStrLen);
  endfunction

  function automatic void deframe_byte(logic [7:0] b);
    logic [31:0] w;
    byte_events.delete();
    if (!closed_flag) begin
      if (ph == PhData) begin
        note(KindByte, b, str_idx, ErrNone);
        if (body_left != 0) body_left = body_left - 1'b1;
        if (str_left != 0) str_left = str_left - 1'b1;
        if (str_left == 0) end_string();
      end else begin
        if (ph != PhLen && body_left != 0) body_left = body_left - 1'b1;
        fld_val = fld_val | (32'(b) << (8 * fld_cnt));
        if (fld_cnt != 2'd3) begin
          fld_cnt = fld_cnt + 1'b1;
        end else begin
          w       = fld_val;
          fld_cnt = '0;
          fld_val = '0;
          case (ph)
            PhCount: begin
              if (w > 32'(lim_strings) || w[31:CntBits] != '0) begin
                close_with(ErrBadReq);
              end else begin
                strs_left = w[CntBits-1:0];
                str_idx   = '0;
                if (w == 0) end_request();
                else need_word(PhStrLen);
              end
            end
            PhStrLen: begin
              if (w > 32'(body_left)) begin
                close_with(ErrBadReq);
              end else begin
                str_left = w[LenBits-1:0];
                if (w == 0) end_string();
                else ph = PhData;
              end
            end
            default: begin
              if (w > 32'(lim_msg_len) || w[31:LenBits] != '0) begin
                close_with(ErrTooLong);
              end else begin
                body_left = w[LenBits-1:0];
                need_word(PhCount);
              end
            end
          endcase
        end
      end
      if (byte_events.size() > 0) byte_events[byte_events.size()-1].last = 1'b1;
    end
  endfunction

  // ---------------------------------------------------------------- request builder

  function automatic void put_word(ref logic [7:0] q[$], input logic [31:0] w);
    for (int i = 0; i < 4; i++) q.insert(q.size(), w[8*i +: 8]);
  endfunction

  // One well-formed request within the current limits
  function automatic void add_request(ref logic [7:0] q[$]);
    int unsigned lens[$];
    int unsigned cnt;
    int unsigned body;
    int unsigned cap;
    cap = (lim_strings < 4) ? lim_strings : 4;
    cnt = $urandom_range(0, cap);
    repeat (cnt) begin
      lens.insert(lens.size(),
                  ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6));
    end
    body = 4;
    foreach (lens[i]) body += 4 + lens[i];
    while (body > lim_msg_len && lens.size() > 0) body -= 4 + lens.pop_back();
    put_word(q, body);
    put_word(q, lens.size());
    foreach (lens[i]) begin
      put_word(q, lens[i]);
      repeat (lens[i]) q.insert(q.size(), 8'($urandom()));
    end
  endfunction

  // ---------------------------------------------------------------- register port

  task automatic reg_read(input logic idx, input logic [31:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== want) begin
      report_mismatch($sformatf("register %0d reads %h, want %h", idx, prdata, want));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Write, mirror into the predictor, read back
  task automatic reg_write(input logic idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    settings_used++;
    if (idx == RegMaxMsgLen) begin
      lim_msg_len = val[MaxLenWidth-1:0];
      reg_read(idx, 32'(lim_msg_len));
    end else begin
      lim_strings = val[MaxStrWidth-1:0];
      reg_read(idx, 32'(lim_strings));
    end
  endtask

  // ---------------------------------------------------------------- byte side

  task automatic send_byte(input logic [7:0] b);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    bytes_in++;
    deframe_byte(b);
  endtask

  task automatic send_stream(input logic [7:0] q[$]);
    foreach (q[i]) begin
      send_byte(q[i]);
      foreach (byte_events[j]) events_due.insert(events_due.size(), byte_events[j]);
    end
  endtask

  // Random requests until about `target` bytes went in
  task automatic stream_requests(input int target, input bit with_hold);
    logic [7:0] q[$];
    int sent;
    sent = 0;
    while (sent < target) begin
      q.delete();
      add_request(q);
      if (with_hold && sent >= 30) begin
        hold_go   = 1'b1;
        with_hold = 1'b0;
      end
      send_stream(q);
      sent += q.size();
    end
  endtask

  // Registers change only once every due event is out
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (events_due.size() > 0) @(posedge clk_i);
    repeat (IdleGuard) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------- result side

  // Random stall bursts, one long hold on request, none when quiet
  initial begin : result_side
    int burst;
    int calm;
    int held;
    bit hold_done;
    burst       = 0;
    calm        = 0;
    held        = 0;
    hold_done   = 1'b0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_go && !hold_done) begin
        out_stall_i <= 1'b1;
        held++;
        if (held == LongHold) hold_done = 1'b1;
      end else if (quiet) begin
        out_stall_i <= 1'b0;
      end else begin
        if (burst == 0 && calm == 0) begin
          if ($urandom_range(0, 2) == 0) burst = $urandom_range(1, 18);
          else calm = $urandom_range(1, 30);
        end
        if (burst > 0) begin
          out_stall_i <= 1'b1;
          burst--;
        end else begin
          out_stall_i <= 1'b0;
          calm--;
        end
      end
    end
  end

  // Compare each taken result with the oldest due event
  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (events_due.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d payload %h index %0d err %0d",
                                  kind_o, payload_o, string_index_o, error_code_o));
      end else begin
        want = events_due.pop_front();
        if (kind_o !== want.kind)
          report_mismatch($sformatf("kind %0d, want %0d", kind_o, want.kind));
        if (payload_o !== want.payload)
          report_mismatch($sformatf("payload %h, want %h", payload_o, want.payload));
        if (string_index_o !== want.string_index)
          report_mismatch($sformatf("string index %0d, want %0d", string_index_o,
                                    want.string_index));
        if (error_code_o !== want.error_code)
          report_mismatch($sformatf("error code %0d, want %0d", error_code_o, want.error_code));
        if (last_o !== want.last)
          report_mismatch($sformatf("last %b, want %b", last_o, want.last));
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  initial begin : stimulus
    stim_row_t   dir_tab [25];
    logic [7:0]  q[$];
    logic [31:0] w;
    int          scen;
    string       closing;

    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    rx_byte_i  = 8'h00;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    quiet      = 1'b0;
    hold_go    = 1'b0;

    ph          = PhLen;
    fld_cnt     = '0;
    fld_val     = '0;
    body_left   = '0;
    strs_left   = '0;
    str_left    = '0;
    str_idx     = '0;
    closed_flag = 1'b0;
    lim_msg_len = MaxMsgLenReset;
    lim_strings = MaxStringsReset;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Limits come up at their defaults
    reg_read(RegMaxMsgLen, 32'(MaxMsgLenReset));
    reg_read(RegMaxStrings, 32'(MaxStringsReset));

    // Directed table: empty string, one 8'hFF string closing both string and
    // request on one byte, then a request with no strings
    foreach (dir_tab[i]) begin
      dir_tab[i].b = DirBytes[i];
      dir_tab[i].n = (i < 4) ? 0 : -1;
    end
    dir_tab[11].n    = 1;
    dir_tab[11].r[0] = make_event(KindStrDone, 8'h00, 18'd0, ErrNone, 1'b1);
    dir_tab[16].n    = 3;
    dir_tab[16].r[0] = make_event(KindByte, 8'hFF, 18'd1, ErrNone, 1'b0);
    dir_tab[16].r[1] = make_event(KindStrDone, 8'h00, 18'd1, ErrNone, 1'b0);
    dir_tab[16].r[2] = make_event(KindReqDone, 8'h00, 18'd0, ErrNone, 1'b1);
    dir_tab[24].n    = 1;
    dir_tab[24].r[0] = make_event(KindReqDone, 8'h00, 18'd0, ErrNone, 1'b1);

    foreach (dir_tab[i]) begin
      send_byte(dir_tab[i].b);
      if (dir_tab[i].n < 0) begin
        foreach (byte_events[j]) events_due.insert(events_due.size(), byte_events[j]);
      end else begin
        for (int j = 0; j < dir_tab[i].n; j++) begin
          events_due.insert(events_due.size(), dir_tab[i].r[j]);
        end
      end
    end

    // Tightest limits that still pass a request: no strings, 4-byte body
    wait_idle();
    reg_write(RegMaxStrings, 32'd0);
    reg_write(RegMaxMsgLen, 32'd4);
    q.delete();
    repeat (3) add_request(q);
    send_stream(q);

    // Widest limits, with one long hold-off on the result side
    wait_idle();
    reg_write(RegMaxMsgLen, 32'h03FF_FFFF);
    reg_write(RegMaxStrings, 32'h0003_FFFF);
    stream_requests(90, 1'b1);

    // Small random limits
    repeat (2) begin
      wait_idle();
      reg_write(RegMaxMsgLen, $urandom_range(12, 80));
      reg_write(RegMaxStrings, $urandom_range(2, 5));
      stream_requests(50, 1'b0);
    end

    // Last stretch without idling on either side
    quiet = 1'b1;
    stream_requests(25, 1'b0);

    // One malformed request closes the unit; trailing bytes must be dropped
    scen = $urandom_range(0, 6);
    q.delete();
    case (scen)
      0: begin
        if ($urandom_range(0, 1) == 1) begin
          wait_idle();
          reg_write(RegMaxMsgLen, 32'd0);
        end
        put_word(q, 32'(lim_msg_len) + 32'd1 + $urandom_range(0, 100));
        closing = "body length over the limit";
      end
      1: begin
        wait_idle();
        reg_write(RegMaxMsgLen, 32'h03FF_FFFF);
        w = ($urandom_range(0, 1) == 1) ? 32'hFFFF_FFFF : (32'h0400_0000 | $urandom_range(0, 255));
        put_word(q, w);
        closing = "body length wider than the length field";
      end
      2: begin
        put_word(q, $urandom_range(0, 3));
        closing = "body too short for the string count";
      end
      3: begin
        if ($urandom_range(0, 1) == 1) begin
          wait_idle();
          reg_write(RegMaxStrings, 32'h0003_FFFF);
          w = 32'h0004_0000 + $urandom_range(0, 9);
        end else begin
          w = 32'(lim_strings) + 32'd1 + $urandom_range(0, 9);
        end
        put_word(q, 32'd8);
        put_word(q, w);
        closing = "string count over the limit";
      end
      4: begin
        put_word(q, 32'd12);
        put_word(q, 32'd1);
        put_word(q, 32'd5 + $urandom_range(0, 20));
        closing = "string longer than the rest of the body";
      end
      5: begin
        if ($urandom_range(0, 1) == 1) begin
          put_word(q, 32'd9);
          put_word(q, 32'd1);
          put_word(q, 32'd0);
        end else begin
          put_word(q, 32'd5);
          put_word(q, 32'd0);
        end
        closing = "bytes left over after the last string";
      end
      default: begin
        put_word(q, 32'd10);
        put_word(q, 32'd2);
        put_word(q, 32'd0);
        closing = "body ends before the next string length";
      end
    endcase
    repeat (12) q.insert(q.size(), 8'($urandom()));
    send_stream(q);

    // Drain
    in_valid_i <= 1'b0;
    while (events_due.size() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("%0d bytes in, %0d results checked over %0d register writes",
             bytes_in, results_seen, settings_used);
    $display("closing case: %s", closing);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
